/* rtl/cbrp_pkg.sv */
// Package for the camera bridge register files and packetizer.
// Types, codes, register default tables and packet constants; no dependencies.
`default_nettype none

package cbrp_pkg;

   localparam int unsigned REG_COUNT = 256;
   localparam int unsigned IDX_W     = 8;

   // bridge registers involved in sensor transfers
   localparam logic [7:0] XFER_DST_IDX  = 8'h42;
   localparam logic [7:0] XFER_SRC_IDX  = 8'h43;
   localparam logic [7:0] XFER_DATA_IDX = 8'h45;
   localparam logic [7:0] XFER_CTRL_IDX = 8'h47;
   localparam logic [7:0] XFER_PUT      = 8'h01;
   localparam logic [7:0] XFER_GET      = 8'h05;

   localparam int unsigned HDR_BYTES     = 16;
   localparam logic [15:0] FOOTER_STATE  = 16'd25;
   localparam logic [15:0] REARM_STATE   = 16'd30;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_TOKEN  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_CTRL   = 3'd0,
      KIND_HEADER = 3'd1,
      KIND_DATA   = 3'd2,
      KIND_FOOTER = 3'd3,
      KIND_NAK    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      RD_SEL_REQ = 2'd0,
      RD_SEL_DST = 2'd1,
      RD_SEL_SRC = 2'd2
   } rd_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_RD_RSP,
      S_PUT_WR,
      S_GET_RD,
      S_GET_WR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  reg_index;
      logic [7:0]  write_data;
      logic [15:0] read_length;
      logic [17:0] frame_size;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [15:0] byte_count;
      logic [2:0]  packet_kind;
      logic [17:0] data_offset;
      logic [9:0]  data_count;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       br_rd;
      rd_sel_type br_rd_sel;
      logic       sn_rd;
      logic       sn_wr;
      logic       br_wr_fetch;
      logic       br_wr_req;
      logic       token_step;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   xfer_put;
      logic   xfer_get;
   } status_type;

   localparam logic [7:0] BRIDGE_INIT [REG_COUNT] = '{
      8'hc0,8'h00,8'ha8,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h00,8'h00,8'h00,8'h00,
      8'h14,8'h1e,8'h00,8'h00,8'h00,8'h00,8'h00,8'h40,8'h00,8'h00,8'h00,8'h44,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h08,8'h98,8'hff,8'h00,8'h03,8'h00,8'h00,8'h1e,8'h01,8'hf1,8'h00,8'h01,8'h00,8'h00,8'h00,
      8'hff,8'hff,8'hff,8'hff,8'h50,8'h51,8'h52,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h05,8'h3b,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'hff,8'h00,8'h01,8'h00,8'h21,8'h00,8'h02,8'h6d,8'h0e,8'h00,8'h02,8'h00,8'h11,
      8'h00,8'h00,8'h0f,8'h00,8'h00,8'h00,8'h00,8'h00,8'h05,8'h04,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'hb4,8'h00,8'hff,8'h00,8'hff,8'h00,8'h00,8'hff,8'h03,8'h03,8'hfc,8'h00,8'hff,8'h00,8'h00,8'hff,
      8'h00,8'h00,8'hff,8'h00,8'hff,8'h00,8'h00,8'hff,8'h00,8'h00,8'h00,8'h00,8'h7f,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h33,8'h04,8'h40,8'h40,8'h0c,8'h3f,8'h00,8'h00,8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h0a,8'h0f,8'h1e,8'h2d,8'hff,8'h00,8'hff,8'h00,8'hff,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h01,8'h02,8'h03,8'h00,8'h05,8'h02,8'h07,8'h00,8'h09,8'h02,8'h0b,8'h00,8'h0d,8'h02,8'h0f,
      8'h00,8'h11,8'h02,8'h13,8'h00,8'h15,8'h02,8'h17,8'h00,8'h19,8'h02,8'h1b,8'h00,8'h1d,8'h02,8'h1f,
      8'h50,8'h64,8'h82,8'h96,8'h82,8'h81,8'h00,8'h01,8'h02,8'h00,8'h10,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h20,8'h40,8'h60,8'h80,8'ha0,8'hc0,8'he0,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
   };

   localparam logic [7:0] SENSOR_INIT [REG_COUNT] = '{
      8'h00,8'h84,8'h84,8'h84,8'h34,8'h3e,8'h80,8'h8c,8'h00,8'h00,8'h76,8'h48,8'h7b,8'h5b,8'h00,8'h98,
      8'h57,8'h00,8'h14,8'ha3,8'h04,8'h00,8'h00,8'h1a,8'hba,8'h03,8'hf3,8'h00,8'h7f,8'ha2,8'h00,8'h01,
      8'hc0,8'h80,8'h80,8'hde,8'h10,8'h8a,8'ha2,8'he2,8'h20,8'h00,8'h00,8'h00,8'h88,8'h81,8'h00,8'h94,
      8'h40,8'ha0,8'hc0,8'h16,8'h16,8'h00,8'h00,8'h82,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h01,
      8'h01,8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,
      8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hca,8'h00,
      8'h06,8'he0,8'h88,8'h11,8'h89,8'h02,8'h55,8'h01,8'h7a,8'h04,8'h00,8'h00,8'h11,8'h01,8'h06,8'h00,
      8'h01,8'h00,8'h10,8'h50,8'h20,8'h02,8'h00,8'hf3,8'h80,8'h80,8'h80,8'h00,8'h00,8'h47,8'h27,8'h8a,
      8'h83,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h01,8'h01,8'h01,8'h01,8'h83,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1f,8'h1f,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
      8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,8'h82,8'h00,
      8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
      8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00,8'h7e,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h01,8'h01,
      8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h83,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h75,8'h75,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
   };

endpackage

`default_nettype wire

/* rtl/camera_bridge_regs_and_packetizer.sv */
// Top level of the camera bridge: register files and frame packetizer.
// Depends on cbrp_pkg, cbrp_ctrl and cbrp_datapath.
//
// One request is taken at a time: it is accepted on a clock edge with start high and busy
// low, and its single result appears on rsp_item for exactly one cycle with rsp_strobe high;
// the receiver must take it then. busy drops in the strobe cycle, so the next request may be
// accepted in that same cycle. The sequencer path depends on the request: a plain register
// write, an IN token or an unused operation only dispatch; a register read adds a read-response
// state after the registered read port; a write of 1 to index 0x47 does bridge read, sensor
// write, bridge write; and a write of 5 to index 0x47 does bridge read, sensor read, two
// bridge writes. Both register files start from their default tables straight out of reset;
// no clearing pass is needed.
`default_nettype none

module camera_bridge_regs_and_packetizer
   import cbrp_pkg::*;
#(
   parameter int unsigned PACKET_BYTES    = 768,
   parameter int unsigned MAX_FRAME_BYTES = 262144
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output rsp_type      rsp_item,
   output logic         rsp_strobe
);

   cmd_type    cmd;
   status_type status;

   cbrp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   cbrp_datapath #(
      .PACKET_BYTES    (PACKET_BYTES),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_item   (req_item),
      .status     (status),
      .rsp_item   (rsp_item),
      .rsp_strobe (rsp_strobe)
   );

   // an accepted beat always starts a busy period
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // a result only follows a busy period and lands as busy drops
   a_strobe_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result strobe outside the end of a request");

   // no packet carries more frame bytes than a packet holds
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_item.data_count) <= PACKET_BYTES))
      else $error("packet data count above packet size");

   // only IN tokens advance the frame walker
   a_token_only : assert property (@(posedge clock) disable iff (reset)
      cmd.token_step |-> (status.op == OP_TOKEN))
      else $error("frame walker stepped on a non-token request");

endmodule

`default_nettype wire

/* rtl/cbrp_ctrl.sv */
// Sequencer for the camera bridge: one request at a time, issues datapath commands.
// Depends on cbrp_pkg.
`default_nettype none

module cbrp_ctrl
   import cbrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output logic            busy,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.op)
               OP_WRITE: begin
                  if (status.xfer_put) begin
                     cmd.br_rd     = 1'b1;
                     cmd.br_rd_sel = RD_SEL_DST;
                     state_in      = S_PUT_WR;
                  end else if (status.xfer_get) begin
                     cmd.br_rd     = 1'b1;
                     cmd.br_rd_sel = RD_SEL_SRC;
                     state_in      = S_GET_RD;
                  end else begin
                     cmd.br_wr_req = 1'b1;
                     cmd.rsp_load  = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               OP_READ: begin
                  cmd.br_rd     = 1'b1;
                  cmd.br_rd_sel = RD_SEL_REQ;
                  state_in      = S_RD_RSP;
               end
               OP_TOKEN: begin
                  cmd.token_step = 1'b1;
                  cmd.rsp_load   = 1'b1;
                  state_in       = S_IDLE;
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_RD_RSP: begin
            cmd.rsp_load = 1'b1;
            state_in     = S_IDLE;
         end
         S_PUT_WR: begin
            cmd.sn_wr = 1'b1;
            state_in  = S_FINISH;
         end
         S_GET_RD: begin
            cmd.sn_rd = 1'b1;
            state_in  = S_GET_WR;
         end
         S_GET_WR: begin
            cmd.br_wr_fetch = 1'b1;
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            cmd.br_wr_req = 1'b1;
            cmd.rsp_load  = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/cbrp_datapath.sv */
// Datapath: request register, bridge and sensor register files, frame walker, result register.
// Depends on cbrp_pkg.
`default_nettype none

module cbrp_datapath
   import cbrp_pkg::*;
#(
   parameter int unsigned PACKET_BYTES    = 768,
   parameter int unsigned MAX_FRAME_BYTES = 262144
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire req_type    req_item,
   output status_type      status,
   output rsp_type         rsp_item,
   output logic            rsp_strobe
);

   localparam logic [17:0] FirstBytes = 18'(PACKET_BYTES - HDR_BYTES);
   localparam logic [17:0] PktBytes18 = 18'(PACKET_BYTES);
   localparam logic [15:0] PktBytes16 = 16'(PACKET_BYTES);
   localparam logic [19:0] FrameLast  = 20'(MAX_FRAME_BYTES - 1);

   req_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
   end

   assign status.op       = op_type'(req_ff.operation);
   assign status.xfer_put = (req_ff.reg_index == XFER_CTRL_IDX) && (req_ff.write_data == XFER_PUT);
   assign status.xfer_get = (req_ff.reg_index == XFER_CTRL_IDX) && (req_ff.write_data == XFER_GET);

   // ---------------- bridge register file: two read ports, one write port
   logic [7:0]           br_mem [REG_COUNT];
   logic [REG_COUNT-1:0] br_valid_ff;
   logic [IDX_W-1:0]     br_addr_a, br_addr_a_ff, br_addr_b_ff, br_wr_addr;
   logic [7:0]           br_q_a_ff, br_q_b_ff, br_wr_data;
   logic                 br_v_a_ff, br_v_b_ff, br_we;
   logic [7:0]           br_data_a, br_data_b;

   always_comb begin
      case (cmd.br_rd_sel)
         RD_SEL_DST: br_addr_a = XFER_DST_IDX;
         RD_SEL_SRC: br_addr_a = XFER_SRC_IDX;
         default:    br_addr_a = req_ff.reg_index;
      endcase
   end

   // sensor read data (declared here, used by the fetch write)
   logic [7:0]           sn_mem [REG_COUNT];
   logic [REG_COUNT-1:0] sn_valid_ff;
   logic [IDX_W-1:0]     sn_addr_ff;
   logic [7:0]           sn_q_ff;
   logic                 sn_v_ff;
   logic [7:0]           sn_data;

   assign br_we      = cmd.br_wr_fetch | cmd.br_wr_req;
   assign br_wr_addr = cmd.br_wr_fetch ? XFER_DATA_IDX : req_ff.reg_index;
   assign br_wr_data = cmd.br_wr_fetch ? sn_data : req_ff.write_data;

   always_ff @(posedge clock) begin
      if (br_we) begin
         br_mem[br_wr_addr] <= br_wr_data;
      end
      if (cmd.br_rd) begin
         br_q_a_ff    <= br_mem[br_addr_a];
         br_q_b_ff    <= br_mem[XFER_DATA_IDX];
         br_v_a_ff    <= br_valid_ff[br_addr_a];
         br_v_b_ff    <= br_valid_ff[XFER_DATA_IDX];
         br_addr_a_ff <= br_addr_a;
         br_addr_b_ff <= XFER_DATA_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         br_valid_ff <= '0;
      end else if (br_we) begin
         br_valid_ff[br_wr_addr] <= 1'b1;
      end
   end

   // entries never written read back their default
   assign br_data_a = br_v_a_ff ? br_q_a_ff : BRIDGE_INIT[br_addr_a_ff];
   assign br_data_b = br_v_b_ff ? br_q_b_ff : BRIDGE_INIT[br_addr_b_ff];

   // ---------------- sensor register file: address always from bridge port A
   always_ff @(posedge clock) begin
      if (cmd.sn_wr) begin
         sn_mem[br_data_a] <= br_data_b;
      end
      if (cmd.sn_rd) begin
         sn_q_ff    <= sn_mem[br_data_a];
         sn_v_ff    <= sn_valid_ff[br_data_a];
         sn_addr_ff <= br_data_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sn_valid_ff <= '0;
      end else if (cmd.sn_wr) begin
         sn_valid_ff[br_data_a] <= 1'b1;
      end
   end

   assign sn_data = sn_v_ff ? sn_q_ff : SENSOR_INIT[sn_addr_ff];

   // ---------------- frame walker
   logic [15:0] pkt_count_ff, pkt_count_in;
   logic [17:0] frame_off_ff, frame_off_in;
   logic [17:0] frame_len_ff, frame_len_in;
   logic [17:0] remain, chunk, frame_sat;
   rsp_type     token_rsp;

   always_comb begin
      remain    = frame_len_ff - frame_off_ff;
      chunk     = (remain > PktBytes18) ? PktBytes18 : remain;
      frame_sat = ({2'b00, req_ff.frame_size} > FrameLast) ? FrameLast[17:0]
                                                          : req_ff.frame_size;
      pkt_count_in = pkt_count_ff;
      frame_off_in = frame_off_ff;
      frame_len_in = frame_len_ff;
      token_rsp    = '0;
      if (pkt_count_ff == 16'd0) begin
         frame_len_in          = frame_sat;
         frame_off_in          = FirstBytes;
         pkt_count_in          = 16'd1;
         token_rsp.byte_count  = PktBytes16;
         token_rsp.packet_kind = KIND_HEADER;
         token_rsp.data_count  = FirstBytes[9:0];
      end else if (frame_off_ff < frame_len_ff) begin
         frame_off_in          = frame_off_ff + chunk;
         pkt_count_in          = pkt_count_ff + 16'd1;
         token_rsp.byte_count  = PktBytes16;
         token_rsp.packet_kind = KIND_DATA;
         token_rsp.data_offset = frame_off_ff;
         token_rsp.data_count  = chunk[9:0];
      end else if (pkt_count_ff == REARM_STATE) begin
         pkt_count_in          = 16'd0;
         token_rsp.packet_kind = KIND_NAK;
      end else if (pkt_count_ff >= FOOTER_STATE) begin
         pkt_count_in          = pkt_count_ff + 16'd1;
         token_rsp.packet_kind = KIND_NAK;
      end else begin
         pkt_count_in          = FOOTER_STATE;
         token_rsp.byte_count  = PktBytes16;
         token_rsp.packet_kind = KIND_FOOTER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_count_ff <= '0;
         frame_off_ff <= '0;
         frame_len_ff <= '0;
      end else if (cmd.token_step) begin
         pkt_count_ff <= pkt_count_in;
         frame_off_ff <= frame_off_in;
         frame_len_ff <= frame_len_in;
      end
   end

   // ---------------- result register
   rsp_type rsp_in, rsp_ff;
   logic    rsp_strobe_ff;

   always_comb begin
      rsp_in = '0;
      case (status.op)
         OP_WRITE: begin
            rsp_in.byte_count = 16'd1;
         end
         OP_READ: begin
            rsp_in.read_data  = br_data_a;
            rsp_in.byte_count = req_ff.read_length;
         end
         OP_TOKEN: begin
            rsp_in = token_rsp;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   assign rsp_item   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking bench for the camera bridge register files and frame packetizer.
// Needs cbrp_pkg and camera_bridge_regs_and_packetizer; every result beat is checked
// field by field against a predictor of the register files and the frame walk.

module testbench;
   import cbrp_pkg::*;

   localparam int unsigned PKT_BYTES   = 768;
   localparam int unsigned FRAME_LIMIT = 262144;
   localparam int unsigned FIRST_BYTES = PKT_BYTES - HDR_BYTES;
   localparam int unsigned RAND_ITEMS  = 1720;
   localparam int unsigned TAIL_ITEMS  = 150;

   typedef struct {
      req_type     rq;
      int unsigned gap_pct;
      bit          wait_idle;
   } stim_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   rsp_type rsp_item;
   logic    rsp_strobe;

   // predictor state
   logic [7:0]  bridge_mem [REG_COUNT];
   logic [7:0]  sensor_mem [REG_COUNT];
   logic [15:0] pkt_cnt;
   logic [17:0] frame_pos;
   logic [17:0] frame_len;

   stim_type    requests_todo [$];
   rsp_type     answers_due [$];
   int unsigned beats_sent = 0;
   int unsigned beats_back = 0;
   int unsigned gap_left   = 0;
   int unsigned gap_pct    = 0;
   int unsigned fail_n     = 0;
   bit          gaps_on    = 1'b0;
   bit          hold_next  = 1'b0;

   camera_bridge_regs_and_packetizer #(
      .PACKET_BYTES    (PKT_BYTES),
      .MAX_FRAME_BYTES (FRAME_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_item   (rsp_item),
      .rsp_strobe (rsp_strobe)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [7:0] rnd8();
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] rnd16();
      return 16'($urandom);
   endfunction

   function automatic logic [17:0] rnd18();
      return 18'($urandom);
   endfunction

   function automatic rsp_type bridge_answer(req_type rq);
      rsp_type     r;
      int unsigned size;
      logic [17:0] n;
      r = '0;
      case (op_type'(rq.operation))
         OP_WRITE: begin
            if (rq.reg_index == XFER_CTRL_IDX) begin
               if (rq.write_data == XFER_PUT)
                  sensor_mem[bridge_mem[XFER_DST_IDX]] = bridge_mem[XFER_DATA_IDX];
               else if (rq.write_data == XFER_GET)
                  bridge_mem[XFER_DATA_IDX] = sensor_mem[bridge_mem[XFER_SRC_IDX]];
            end
            bridge_mem[rq.reg_index] = rq.write_data;
            r.byte_count = 16'd1;
         end
         OP_READ: begin
            r.read_data  = bridge_mem[rq.reg_index];
            r.byte_count = rq.read_length;
         end
         OP_TOKEN: begin
            if (pkt_cnt == 16'd0) begin
               // header always carries the full first slice, even for a short frame
               size = 32'(rq.frame_size);
               if (size > FRAME_LIMIT - 1)
                  size = FRAME_LIMIT - 1;
               frame_len     = size[17:0];
               frame_pos     = 18'(FIRST_BYTES);
               pkt_cnt       = 16'd1;
               r.byte_count  = 16'(PKT_BYTES);
               r.packet_kind = KIND_HEADER;
               r.data_count  = 10'(FIRST_BYTES);
            end else if (frame_pos < frame_len) begin
               n = frame_len - frame_pos;
               if (n > 18'(PKT_BYTES))
                  n = 18'(PKT_BYTES);
               r.data_offset = frame_pos;
               r.data_count  = n[9:0];
               frame_pos     = frame_pos + n;
               pkt_cnt       = pkt_cnt + 16'd1;
               r.byte_count  = 16'(PKT_BYTES);
               r.packet_kind = KIND_DATA;
            end else if (pkt_cnt == REARM_STATE) begin
               pkt_cnt       = 16'd0;
               r.packet_kind = KIND_NAK;
            end else if (pkt_cnt >= FOOTER_STATE) begin
               // NAKs count up to the rearm count; past the rearm count this runs on until the counter wraps
               pkt_cnt       = pkt_cnt + 16'd1;
               r.packet_kind = KIND_NAK;
            end else begin
               pkt_cnt       = FOOTER_STATE;
               r.byte_count  = 16'(PKT_BYTES);
               r.packet_kind = KIND_FOOTER;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_n++;
      end
   endtask

   // driver: one request beat at a time, idle bursts only after an accepted beat
   always @(posedge clock) begin : driver
      bit       fire;
      stim_type nxt;
      fire = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (fire) begin
            answers_due.push_back(bridge_answer(req_item));
            beats_sent <= beats_sent + 1;
         end
         if (fire || !start) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               start    <= 1'b0;
            end else if (fire && requests_todo.size() != 0
                         && $urandom_range(99) < requests_todo[0].gap_pct) begin
               gap_left <= $urandom_range(12);   // this cycle is the first idle one
               start    <= 1'b0;
            end else if (requests_todo.size() != 0 && (!requests_todo[0].wait_idle
                         || (!fire && beats_sent == beats_back))) begin
               nxt = requests_todo.pop_front();
               req_item <= nxt.rq;
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type due;
      if (!reset && rsp_strobe) begin
         beats_back <= beats_back + 1;
         if (beats_sent == beats_back) begin
            $error("result beat with nothing outstanding: %h", rsp_item);
            fail_n++;
         end else begin
            due = answers_due.pop_front();
            check_field("read_data",   32'(due.read_data),   32'(rsp_item.read_data));
            check_field("byte_count",  32'(due.byte_count),  32'(rsp_item.byte_count));
            check_field("packet_kind", 32'(due.packet_kind), 32'(rsp_item.packet_kind));
            check_field("data_offset", 32'(due.data_offset), 32'(rsp_item.data_offset));
            check_field("data_count",  32'(due.data_count),  32'(rsp_item.data_count));
         end
      end
   end

   task automatic queue_req(input op_type op, input logic [7:0] idx, input logic [7:0] wd,
                            input logic [15:0] rlen, input logic [17:0] fsz);
      stim_type e;
      e.rq.operation   = op;
      e.rq.reg_index   = idx;
      e.rq.write_data  = wd;
      e.rq.read_length = rlen;
      e.rq.frame_size  = fsz;
      e.gap_pct        = gap_pct;
      e.wait_idle      = hold_next;
      hold_next        = 1'b0;
      requests_todo.push_back(e);
   endtask

   // frame sizes stay below the point where the counter would run past the rearm count
   function automatic logic [17:0] frame_pick();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 15)
         return 18'($urandom_range(FIRST_BYTES, 0));
      else if (sel < 75)
         return 18'($urandom_range(FIRST_BYTES + 28 * PKT_BYTES, FIRST_BYTES + 1));
      else
         return 18'($urandom_range(FIRST_BYTES + 29 * PKT_BYTES,
                                   FIRST_BYTES + 28 * PKT_BYTES + 1));
   endfunction

   task automatic queue_episode(output int unsigned made);
      int unsigned sel;
      logic [7:0]  dst;
      logic [7:0]  byte_v;
      if (gaps_on && $urandom_range(39) == 0)
         gap_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 15);
      sel    = $urandom_range(99);
      dst    = rnd8();
      byte_v = rnd8();
      made   = 1;
      if (sel < 40) begin
         made = $urandom_range(40, 1);
         repeat (made)
            queue_req(OP_TOKEN, rnd8(), rnd8(), rnd16(), frame_pick());
      end else if (sel < 54) begin
         queue_req(OP_WRITE, rnd8(), rnd8(), rnd16(), rnd18());
      end else if (sel < 68) begin
         if ($urandom_range(3) == 0)
            dst = XFER_DST_IDX + 8'($urandom_range(5));
         queue_req(OP_READ, dst, rnd8(), rnd16(), rnd18());
      end else if (sel < 76) begin
         queue_req(OP_WRITE, XFER_DST_IDX, dst, rnd16(), rnd18());
         queue_req(OP_WRITE, XFER_DATA_IDX, byte_v, rnd16(), rnd18());
         queue_req(OP_WRITE, XFER_CTRL_IDX, XFER_PUT, rnd16(), rnd18());
         made = 3;
         if ($urandom_range(1) == 1) begin
            // read the sensor byte straight back through the bridge
            queue_req(OP_WRITE, XFER_SRC_IDX, dst, rnd16(), rnd18());
            queue_req(OP_WRITE, XFER_CTRL_IDX, XFER_GET, rnd16(), rnd18());
            queue_req(OP_READ, XFER_DATA_IDX, rnd8(), rnd16(), rnd18());
            made = 6;
         end
      end else if (sel < 84) begin
         queue_req(OP_WRITE, XFER_SRC_IDX, dst, rnd16(), rnd18());
         queue_req(OP_WRITE, XFER_CTRL_IDX, XFER_GET, rnd16(), rnd18());
         queue_req(OP_READ, XFER_DATA_IDX, rnd8(), rnd16(), rnd18());
         made = 3;
      end else if (sel < 89) begin
         while (byte_v == XFER_PUT || byte_v == XFER_GET)
            byte_v = rnd8();
         queue_req(OP_WRITE, XFER_CTRL_IDX, byte_v, rnd16(), rnd18());
      end else if (sel < 94) begin
         queue_req(OP_UNUSED, rnd8(), rnd8(), rnd16(), rnd18());
      end else if (sel < 99) begin
         queue_req(OP_WRITE, dst, byte_v, rnd16(), rnd18());
         queue_req(OP_READ, dst, rnd8(), rnd16(), rnd18());
         made = 2;
      end else begin
         hold_next = 1'b1;
         queue_req(OP_READ, dst, rnd8(), rnd16(), rnd18());
      end
   endtask

   task automatic wait_drained();
      while (requests_todo.size() != 0 || start || beats_sent != beats_back)
         @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned made_total;
      int unsigned n;
      for (int i = 0; i < REG_COUNT; i++) begin
         bridge_mem[i] = BRIDGE_INIT[i];
         sensor_mem[i] = SENSOR_INIT[i];
      end
      pkt_cnt   = '0;
      frame_pos = '0;
      frame_len = '0;

      // directed: field extremes, both sensor transfers, plain store to the control index
      queue_req(OP_READ,   8'h00, 8'h00, 16'h0000, 18'h00000);
      queue_req(OP_READ,   8'hff, 8'hff, 16'hffff, 18'h3ffff);
      queue_req(OP_WRITE,  8'hff, 8'hff, 16'hffff, 18'h3ffff);
      queue_req(OP_WRITE,  8'h00, 8'h00, 16'h0000, 18'h00000);
      queue_req(OP_READ,   8'hff, 8'h00, 16'h0001, 18'h00000);
      queue_req(OP_UNUSED, 8'hff, 8'hff, 16'hffff, 18'h3ffff);
      queue_req(OP_WRITE,  XFER_DST_IDX,  8'h10, 16'h0000, 18'h00000);
      queue_req(OP_WRITE,  XFER_DATA_IDX, 8'hab, 16'h0000, 18'h00000);
      queue_req(OP_WRITE,  XFER_CTRL_IDX, XFER_PUT, 16'h0000, 18'h00000);
      queue_req(OP_WRITE,  XFER_SRC_IDX,  8'h10, 16'h0000, 18'h00000);
      queue_req(OP_WRITE,  XFER_DATA_IDX, 8'h00, 16'h0000, 18'h00000);
      queue_req(OP_WRITE,  XFER_CTRL_IDX, XFER_GET, 16'h0000, 18'h00000);
      queue_req(OP_READ,   XFER_DATA_IDX, 8'h00, 16'h0001, 18'h00000);
      queue_req(OP_WRITE,  XFER_CTRL_IDX, 8'h07, 16'h0000, 18'h00000);
      queue_req(OP_READ,   XFER_CTRL_IDX, 8'h00, 16'h0002, 18'h00000);
      // empty frame: header, footer, then NAKs up to the rearm
      repeat (8)
         queue_req(OP_TOKEN, 8'h00, 8'h00, 16'h0000, 18'h00000);

      gaps_on    = 1'b1;
      gap_pct    = 30;
      made_total = 0;
      while (made_total < RAND_ITEMS) begin
         queue_episode(n);
         made_total += n;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sender holds off until every outstanding result is back, then runs without gaps
      wait_drained();
      gaps_on = 1'b0;
      gap_pct = 0;

      made_total = 0;
      while (made_total < TAIL_ITEMS) begin
         queue_episode(n);
         made_total += n;
      end

      wait_drained();
      repeat (12) @(negedge clock);
      if (answers_due.size() != 0) begin
         $error("%0d expected results never arrived", answers_due.size());
         fail_n++;
      end
      if (fail_n == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* camera_bridge_regs_and_packetizer.f */
rtl/cbrp_pkg.sv
rtl/cbrp_ctrl.sv
rtl/cbrp_datapath.sv
rtl/camera_bridge_regs_and_packetizer.sv
tb/testbench.sv
